FILE: hdl/mean_and_std_deviation_macros.svh
// Assertion macros for the mean/std deviation checker.
`ifndef MEAN_AND_STD_DEVIATION_MACROS_SVH
`define MEAN_AND_STD_DEVIATION_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define MSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/msd_pkg.sv
// Package: field widths, status codes and sequencer states for the statistics block.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

  localparam int SMP_W  = 16;
  localparam int MEAN_W = 16;
  localparam int VAR_W  = 34;
  localparam int SD_W   = 17;
  localparam int CNTO_W = 11;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FEW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROP = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_MUL,
    ST_MDIV,
    ST_VDIV,
    ST_ROOT,
    ST_OUT
  } msd_state_t;

endpackage

`default_nettype wire

FILE: hdl/msd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module msd_div #(
  parameter int N_W = 52,
  parameter int D_W = 22
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [N_W-1:0]      quotient
);

  localparam int C_W = $clog2(N_W);

  logic           busy_r;
  logic           done_r;
  logic [C_W-1:0] cnt_r;
  logic [N_W-1:0] quo_r;
  logic [D_W-1:0] rem_r;
  logic [D_W-1:0] den_r;

  logic [D_W:0]   rem_sh;
  logic [D_W:0]   rem_diff;
  logic           fits;

  always_comb begin
    rem_sh   = {rem_r, quo_r[N_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    fits     = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
      cnt_r <= C_W'(N_W - 1);
    end else if (busy_r) begin
      // dividend bits shift out the top while quotient bits shift in below
      quo_r <= {quo_r[N_W-2:0], fits};
      rem_r <= fits ? rem_diff[D_W-1:0] : rem_sh[D_W-1:0];
      cnt_r <= cnt_r - C_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: hdl/msd_sqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module msd_sqrt
  import msd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAR_W-1:0] radicand,
  output logic                  done,
  output logic [SD_W-1:0]       root
);

  localparam int C_W = $clog2(SD_W);

  logic             busy_r;
  logic             done_r;
  logic [C_W-1:0]   cnt_r;
  logic [VAR_W-1:0] rad_r;
  logic [SD_W:0]    rem_r;
  logic [SD_W-1:0]  root_r;

  logic [SD_W+2:0]  rem_sh;
  logic [SD_W+2:0]  trial;
  logic [SD_W+2:0]  rem_diff;
  logic             fits;

  always_comb begin
    rem_sh   = {rem_r, rad_r[VAR_W-1:VAR_W-2]};
    trial    = {1'b0, root_r, 2'b01};
    rem_diff = rem_sh - trial;
    fits     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // remainder never exceeds twice the partial root, so SD_W+1 bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= C_W'(SD_W - 1);
    end else if (busy_r) begin
      rad_r  <= {rad_r[VAR_W-3:0], 2'b00};
      rem_r  <= fits ? rem_diff[SD_W:0] : rem_sh[SD_W:0];
      root_r <= {root_r[SD_W-2:0], fits};
      cnt_r  <= cnt_r - C_W'(1);
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: hdl/mean_and_std_deviation.sv
// Top level: two-pass mean, variance and standard deviation over a sample memory.
`timescale 1ns / 1ps
`default_nettype none

// Samples (signed Q8.8) are taken one per cycle and written to an on-chip sample
// memory of MAX_SAMPLES entries; samples beyond that are dropped and the set is
// flagged with status 2. The item with in_last set closes the set: its sample is
// stored first, then the block stops taking items while it reads the memory back
// once (one read port) to sum the squares, forms N*sum(x^2) by shift-and-add over
// the count bits, runs two serial divisions (mean, then variance; one quotient bit
// per cycle) and a serial square root. Variance uses the exact mean and divides by
// N-1 when sample_mode is 1 (reset value) or by N when it is 0. Too few samples
// (none, or one in sample mode) gives status 1 and zero statistics. The result
// waits in an output register, so loading of the next set may start while it is
// still pending. The memory needs no clearing after reset.
module mean_and_std_deviation
  import msd_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [SMP_W-1:0]  in_sample,
  input  wire logic                     in_last,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [MEAN_W-1:0]      out_mean,
  output logic [VAR_W-1:0]              out_variance,
  output logic [SD_W-1:0]               out_std_dev,
  output logic [CNTO_W-1:0]             out_sample_count,
  output logic [STAT_W-1:0]             out_status,
  input  wire logic                     cfg_wr_en,
  input  wire logic                     cfg_wr_data
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SMP_W + CNT_W;
  localparam int MAG_W  = SUM_W - 1;
  localparam int PSQ_W  = 2 * SMP_W - 1;
  localparam int SQ_W   = PSQ_W - 1 + CNT_W;
  localparam int NUM_W  = SQ_W + CNT_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int MC_W   = $clog2(CNT_W);

  msd_state_t state_r, state_nxt;

  logic                     sample_mode_r;
  logic [CNT_W-1:0]         count_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     ovf_r;

  logic signed [SMP_W-1:0]  mem [MAX_SAMPLES];

  logic [CNT_W-1:0]         n_r;
  logic signed [SUM_W-1:0]  tot_r;
  logic [STAT_W-1:0]        status_r;
  logic [CNT_W-1:0]         idx_r;
  logic                     rd_vld_r;
  logic signed [SMP_W-1:0]  rdata_r;
  logic                     sq_vld_r;
  logic [PSQ_W-1:0]         sq_r;
  logic [SQ_W-1:0]          sumsq_r;
  logic [NUM_W-1:0]         s2_r;
  logic [DEN_W-1:0]         den_r;
  logic [CNT_W-1:0]         mul_n_r;
  logic [MC_W-1:0]          mul_cnt_r;
  logic [NUM_W-1:0]         prod_r;
  logic [MEAN_W-1:0]        mean_r;
  logic [VAR_W-1:0]         var_r;
  logic [SD_W-1:0]          sd_r;

  logic                     out_valid_r;
  logic [MEAN_W-1:0]        out_mean_r;
  logic [VAR_W-1:0]         out_var_r;
  logic [SD_W-1:0]          out_sd_r;
  logic [CNTO_W-1:0]        out_cnt_r;
  logic [STAT_W-1:0]        out_stat_r;

  // load side
  logic                     in_fire;
  logic                     has_room;
  logic                     mem_we;
  logic [CNT_W-1:0]         n_new;
  logic signed [SUM_W-1:0]  sum_new;
  logic                     too_few;
  logic [STAT_W-1:0]        status_new;

  // evaluation side
  logic [SUM_W-1:0]         tot_abs;
  logic [MAG_W-1:0]         mag;
  logic [NUM_W-1:0]         mag_sq;
  logic [CNT_W-1:0]         n_div;
  logic [DEN_W-1:0]         den_full;
  logic signed [2*SMP_W-1:0] sq_full;
  logic                     issue;
  logic                     pass_done;
  logic                     mul_last;
  logic                     div_start;
  logic [NUM_W-1:0]         div_dividend;
  logic [DEN_W-1:0]         div_divisor;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;
  logic                     root_start;
  logic                     root_done;
  logic [SD_W-1:0]          root;
  logic [MEAN_W-1:0]        mean_q;
  logic [MEAN_W-1:0]        mean_neg;
  logic                     out_load;

  always_comb begin
    in_fire    = in_valid && in_ready;
    has_room   = (count_r != CNT_W'(MAX_SAMPLES));
    mem_we     = in_fire && has_room;
    n_new      = has_room ? count_r + CNT_W'(1) : count_r;
    sum_new    = has_room ? sum_r + SUM_W'(in_sample) : sum_r;
    too_few    = (n_new == '0) || (sample_mode_r && n_new == CNT_W'(1));
    if (too_few) begin
      status_new = STAT_FEW;
    end else if (ovf_r || !has_room) begin
      status_new = STAT_DROP;
    end else begin
      status_new = STAT_OK;
    end

    tot_abs  = tot_r[SUM_W-1] ? -tot_r : tot_r;
    mag      = tot_abs[MAG_W-1:0];
    mag_sq   = mag * mag;
    n_div    = sample_mode_r ? n_r - CNT_W'(1) : n_r;
    den_full = n_r * n_div;
    sq_full  = rdata_r * rdata_r;
    mean_q   = div_quo[MEAN_W-1:0];
    mean_neg = MEAN_W'(0) - mean_q;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = too_few ? ST_OUT : ST_PASS;
        end
      end
      ST_PASS: begin
        if (pass_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_nxt = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          state_nxt = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (div_done) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // state decodes
  always_comb begin
    in_ready     = (state_r == ST_LOAD);
    issue        = (state_r == ST_PASS) && (idx_r != n_r);
    pass_done    = (state_r == ST_PASS) && !issue && !rd_vld_r && !sq_vld_r;
    mul_last     = (state_r == ST_MUL) && (mul_cnt_r == '0);
    div_start    = mul_last || ((state_r == ST_MDIV) && div_done);
    div_dividend = mul_last ? NUM_W'(mag) : prod_r - s2_r;
    div_divisor  = mul_last ? DEN_W'(n_r) : den_r;
    root_start   = (state_r == ST_VDIV) && div_done;
    out_load     = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_LOAD;
      sample_mode_r <= 1'b1;
      count_r       <= '0;
      sum_r         <= '0;
      ovf_r         <= 1'b0;
      rd_vld_r      <= 1'b0;
      sq_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      sq_vld_r <= rd_vld_r;
      if (cfg_wr_en) begin
        sample_mode_r <= cfg_wr_data;
      end
      if (in_fire) begin
        if (in_last) begin
          count_r <= '0;
          sum_r   <= '0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= n_new;
          sum_r   <= sum_new;
          ovf_r   <= ovf_r || !has_room;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[ADDR_W-1:0]] <= in_sample;
    end
    if (issue) begin
      rdata_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last) begin
      n_r      <= n_new;
      tot_r    <= sum_new;
      status_r <= status_new;
      idx_r    <= '0;
      sumsq_r  <= '0;
      mean_r   <= '0;
      var_r    <= '0;
      sd_r     <= '0;
    end
    if (issue) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    sq_r <= sq_full[PSQ_W-1:0];
    if (sq_vld_r) begin
      sumsq_r <= sumsq_r + SQ_W'(sq_r);
    end
    if (state_r == ST_PASS) begin
      s2_r  <= mag_sq;
      den_r <= den_full;
    end
    // N * sum(x^2), count bits taken from the top
    if (pass_done) begin
      mul_n_r   <= n_r;
      prod_r    <= '0;
      mul_cnt_r <= MC_W'(CNT_W - 1);
    end else if (state_r == ST_MUL) begin
      prod_r    <= {prod_r[NUM_W-2:0], 1'b0} + (mul_n_r[CNT_W-1] ? NUM_W'(sumsq_r) : '0);
      mul_n_r   <= {mul_n_r[CNT_W-2:0], 1'b0};
      mul_cnt_r <= mul_cnt_r - MC_W'(1);
    end
    if (state_r == ST_MDIV && div_done) begin
      mean_r <= tot_r[SUM_W-1] ? mean_neg : mean_q;
    end
    if (root_start) begin
      var_r <= div_quo[VAR_W-1:0];
    end
    if (state_r == ST_ROOT && root_done) begin
      sd_r <= root;
    end
    if (out_load) begin
      out_mean_r <= mean_r;
      out_var_r  <= var_r;
      out_sd_r   <= sd_r;
      out_cnt_r  <= CNTO_W'(n_r);
      out_stat_r <= status_r;
    end
  end

  msd_div #(
    .N_W (NUM_W),
    .D_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  msd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (div_quo[VAR_W-1:0]),
    .done     (root_done),
    .root     (root)
  );

  assign out_valid        = out_valid_r;
  assign out_mean         = out_mean_r;
  assign out_variance     = out_var_r;
  assign out_std_dev      = out_sd_r;
  assign out_sample_count = out_cnt_r;
  assign out_status       = out_stat_r;

endmodule

`default_nettype wire

FILE: hdl/msd_chk.sv
// Port-level checker for the statistics block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "mean_and_std_deviation_macros.svh"

module msd_chk
  import msd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    in_last,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [MEAN_W-1:0] out_mean,
  input wire logic [VAR_W-1:0]        out_variance,
  input wire logic [SD_W-1:0]         out_std_dev,
  input wire logic [STAT_W-1:0]       out_status
);

  // a waiting result stays valid and keeps its mean and variance
  `MSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_variance) && $stable(out_mean), "result changed while stalled")

  // closing a set stops intake while it is evaluated
  `MSD_ASSERT_NEXT(a_last_stall, in_valid && in_ready && in_last, !in_ready, "item taken right after closing a set")

  `MSD_ASSERT_NOW(a_few_zero, out_valid && out_status == STAT_FEW, out_mean == '0 && out_variance == '0 && out_std_dev == '0, "short set with nonzero statistics")

  // std_dev squared does not exceed variance
  `MSD_ASSERT_NOW(a_root_low, out_valid, 35'(out_std_dev) * 35'(out_std_dev) <= 35'(out_variance), "std_dev squared exceeds variance")

endmodule

bind mean_and_std_deviation msd_chk u_msd_chk (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for mean_and_std_deviation: directed set table, then random sets.
module tb_top;
  import msd_pkg::*;

  localparam int STORE_DEPTH     = 1024;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int OVERSIZE_LEN    = STORE_DEPTH + 5;
  localparam int SETTLE_CYCLES   = 200;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [SD_W-1:0]          std_dev;
    logic [CNTO_W-1:0]        sample_count;
    logic [STAT_W-1:0]        status;
  } stats_t;

  typedef struct packed {
    logic [SMP_W-1:0] smp;
    logic             lst;
    logic             mode;
    logic             typed;
    stats_t           stats;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  // Rows with typed = 1 carry a hand-worked result; others go through the predictor.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // sample mode: single item is too few
    '{16'h1234, 1'b1, 1'b1, 1'b1, '{16'sh0000, 34'd0, 17'd0, 11'd1, STAT_FEW}},
    // most negative and most positive: largest two-item spread
    '{16'h8000, 1'b0, 1'b1, 1'b0, '0},
    '{16'h7FFF, 1'b1, 1'b1, 1'b1,
      '{16'sh0000, 34'd2147418112, 17'd46340, 11'd2, STAT_OK}},
    '{16'h8000, 1'b0, 1'b1, 1'b0, '0},
    '{16'h8000, 1'b1, 1'b1, 1'b1, '{16'sh8000, 34'd0, 17'd0, 11'd2, STAT_OK}},
    '{16'h0100, 1'b0, 1'b1, 1'b0, '0},
    '{16'hFF00, 1'b0, 1'b1, 1'b0, '0},
    '{16'h0080, 1'b0, 1'b1, 1'b0, '0},
    '{16'h0001, 1'b0, 1'b1, 1'b0, '0},
    '{16'hFFFF, 1'b1, 1'b1, 1'b0, '0},
    '{16'h5555, 1'b0, 1'b1, 1'b0, '0},
    '{16'hAAAA, 1'b1, 1'b1, 1'b0, '0},
    // population mode: a single item is a valid set
    '{16'h7FFF, 1'b1, 1'b0, 1'b1, '{16'sh7FFF, 34'd0, 17'd0, 11'd1, STAT_OK}},
    '{16'h8000, 1'b1, 1'b0, 1'b1, '{16'sh8000, 34'd0, 17'd0, 11'd1, STAT_OK}},
    '{16'hFFFF, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0001, 1'b1, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b0, 1'b0, '0},
    '{16'h7FFF, 1'b1, 1'b0, 1'b0, '0},
    '{16'h0300, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0300, 1'b0, 1'b0, 1'b0, '0},
    '{16'h0301, 1'b1, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b1, 1'b0, 1'b1, '{16'sh0000, 34'd0, 17'd0, 11'd1, STAT_OK}}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [SMP_W-1:0]  in_sample = '0;
  logic                     in_last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [MEAN_W-1:0] out_mean;
  logic [VAR_W-1:0]         out_variance;
  logic [SD_W-1:0]          out_std_dev;
  logic [CNTO_W-1:0]        out_sample_count;
  logic [STAT_W-1:0]        out_status;
  logic                     cfg_wr_en = 1'b0;
  logic                     cfg_wr_data = 1'b0;

  // predictor state
  logic signed [SMP_W-1:0] sample_mem [STORE_DEPTH];
  int                      samples_held;
  longint                  sample_sum;
  bit                      dropped_any;
  bit                      div_by_n_minus_1;

  stats_t pending_stats [$];
  int     errors;
  int     cycles;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     items_sent;
  int     sets_closed;
  int     few_sets;
  int     dropped_sets;

  mean_and_std_deviation #(
    .MAX_SAMPLES(STORE_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mean         (out_mean),
    .out_variance     (out_variance),
    .out_std_dev      (out_std_dev),
    .out_sample_count (out_sample_count),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_stats.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [SD_W-1:0] floor_root(input logic [VAR_W-1:0] v);
    logic [SD_W-1:0] r;
    logic [SD_W-1:0] trial;
    r = '0;
    for (int b = SD_W - 1; b >= 0; b--) begin
      trial = r | (SD_W'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(v)) r = trial;
    end
    return r;
  endfunction

  // Stores one sample; on a closing item returns 1 with the statistics of the set.
  function automatic bit absorb_sample(input logic signed [SMP_W-1:0] s, input bit closes,
                                       output stats_t res);
    longint          n;
    longint          dv;
    longint          v;
    longint          mag;
    longint unsigned sq;
    longint unsigned num;
    res = '0;
    if (samples_held < STORE_DEPTH) begin
      sample_mem[samples_held] = s;
      samples_held++;
      sample_sum += longint'(s);
    end else begin
      dropped_any = 1'b1;
    end
    if (!closes) return 1'b0;
    n  = samples_held;
    dv = div_by_n_minus_1 ? n - 1 : n;
    res.sample_count = CNTO_W'(n);
    if (n == 0 || dv == 0) begin
      res.status = STAT_FEW;
    end else begin
      res.status = dropped_any ? STAT_DROP : STAT_OK;
      res.mean   = MEAN_W'(sample_sum / n);
      sq = 0;
      for (int i = 0; i < n; i++) begin
        v = sample_mem[i];
        sq += longint'(v * v);
      end
      mag = (sample_sum < 0) ? -sample_sum : sample_sum;
      // exact mean: (N*sum(x^2) - sum(x)^2) / (N*divisor)
      num = longint'(n) * sq - longint'(mag * mag);
      res.variance = VAR_W'(num / longint'(n * dv));
      res.std_dev  = floor_root(res.variance);
    end
    samples_held = 0;
    sample_sum   = 0;
    dropped_any  = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return SMP_W'($urandom_range(511)) - 16'd256;
      default: return SMP_W'($urandom());
    endcase
  endfunction

  function automatic int pick_set_len();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return 1;
    if (r < 70) return $urandom_range(12, 2);
    if (r < 92) return $urandom_range(40, 13);
    return $urandom_range(120, 41);
  endfunction

  // Offers one item, holds it until taken, then updates the expected results.
  task automatic send_item(input logic [SMP_W-1:0] s, input bit closes,
                           input bit typed, input stats_t typed_stats);
    stats_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= closes;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (absorb_sample(s, closes, res)) begin
      sets_closed++;
      if (res.status == STAT_FEW)  few_sets++;
      if (res.status == STAT_DROP) dropped_sets++;
      pending_stats.push_back(typed ? typed_stats : res);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_sample_mode(input bit m);
    drain_results();
    repeat (16) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    div_by_n_minus_1 = m;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    stats_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result, mean %0d count %0d status %0d", $time,
                 out_mean, out_sample_count, out_status);
        errors++;
      end else begin
        exp_s = pending_stats.pop_front();
        check_field("mean", longint'(exp_s.mean), longint'(out_mean));
        check_field("variance", longint'(exp_s.variance), longint'(out_variance));
        check_field("std_dev", longint'(exp_s.std_dev), longint'(out_std_dev));
        check_field("sample_count", longint'(exp_s.sample_count),
                    longint'(out_sample_count));
        check_field("status", longint'(exp_s.status), longint'(out_status));
      end
    end
  end

  initial begin
    int sent;
    int len;
    bit set_open;
    samples_held     = 0;
    sample_sum       = 0;
    dropped_any      = 1'b0;
    div_by_n_minus_1 = 1'b1;
    errors           = 0;
    cycles           = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    items_sent       = 0;
    sets_closed      = 0;
    few_sets         = 0;
    dropped_sets     = 0;
    set_open         = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; mode only changes between sets
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (!set_open && DIR_TABLE[i].mode != div_by_n_minus_1)
        write_sample_mode(DIR_TABLE[i].mode);
      send_item(DIR_TABLE[i].smp, DIR_TABLE[i].lst, DIR_TABLE[i].typed, DIR_TABLE[i].stats);
      set_open = !DIR_TABLE[i].lst;
    end

    // random sets: free flow, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      write_sample_mode(ph % 2 == 0);
      send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 13 : 0;
      recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 13 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = pick_set_len();
        for (int k = 0; k < len; k++) send_item(pick_sample(), k == len - 1, 1'b0, '0);
        sent += len;
      end
      // one set past capacity: the tail is dropped
      if (ph == 3)
        for (int k = 0; k < OVERSIZE_LEN; k++)
          send_item(pick_sample(), k == OVERSIZE_LEN - 1, 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples in %0d sets (%0d too small, %0d over capacity),",
             items_sent, sets_closed, few_sets, dropped_sets);
    $display("both divisor modes, with and without sender gaps and receiver stalls.");
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
